[rtl/prdh_pkg.sv]
// package with register indexes, field widths and reset values of the presence detector
package prdh_pkg;

  // configuration register indexes
  localparam logic [1:0] RegRiseThreshold = 2'd0;
  localparam logic [1:0] RegHoldLength    = 2'd1;
  localparam logic [1:0] RegNearLimit     = 2'd2;

  // fixed field widths
  localparam int unsigned SampleFieldW = 16;
  localparam int unsigned ThresholdW   = 16;
  localparam int unsigned HoldW        = 10;
  localparam int unsigned CfgIndexW    = 2;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned OutDataW     = 8;

  // register reset values
  localparam logic [ThresholdW-1:0] RiseThresholdReset = 16'd800;
  localparam logic [HoldW-1:0]      HoldLengthReset    = 10'd750;
  localparam logic [ThresholdW-1:0] NearLimitReset     = 16'd2600;

  // bit positions in the result tdata
  localparam int unsigned OutDetectedBit   = 0;
  localparam int unsigned OutWindowFullBit = 1;

endpackage

[rtl/presence_rise_detector_hold.sv]
// top level of the presence rise detector with hold
//
// Usage:
// - s_axis carries one distance sample per request in tdata[15:0]; only the low
//   SAMPLE_BITS bits are used. a zero sample while the window fills is ignored.
// - m_axis returns one result per sample: tdata[0] detected, tdata[1] window_full.
// - cfg writes rise_threshold (0), hold_length (1) and near_limit (2); other
//   indexes are dropped. cfg_ready_o is always high; write only while idle.
// Timing:
// - input request to result valid: the accepting edge writes the window ram and
//   reads the oldest entry into the stage register; the result register is loaded
//   after the compare and hold update once the output can take it.
// - one sample per cycle sustained while m_axis_tready is high; the
//   single-port-write / single-read window ram and the registered hold update set that figure.
// Reset:
// - rst_ni clears the write pointer, fill flag, hold state and valid flags and
//   loads the register reset values; the window ram is not cleared, entries
//   are only used in a compare after they are written.
// Stall:
// - when m_axis_tready is low the result stays in the output register, one more
//   sample waits in the stage register, then s_axis_tready drops.
module presence_rise_detector_hold
  import prdh_pkg::*;
#(
  parameter int unsigned WINDOW_GROUPS = 8,
  parameter int unsigned SAMPLE_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SampleFieldW-1:0] s_axis_tdata,  // [15:0] sample
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,     // [0] detected, [1] window_full, rest zero
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned Window = 8 * WINDOW_GROUPS;
  localparam int unsigned PtrW   = $clog2(Window);
  localparam int unsigned DiffW  = ((SAMPLE_BITS > ThresholdW) ? SAMPLE_BITS : ThresholdW) + 2;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Window - 1);

  // configuration registers
  logic [ThresholdW-1:0] rise_thr_q;
  logic [HoldW-1:0]      hold_len_q;
  logic [ThresholdW-1:0] near_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_thr_q <= RiseThresholdReset;
      hold_len_q <= HoldLengthReset;
      near_lim_q <= NearLimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRiseThreshold: rise_thr_q <= cfg_data_i;
        RegHoldLength:    hold_len_q <= cfg_data_i[HoldW-1:0];
        RegNearLimit:     near_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake and pipeline control
  logic in_acc, adv;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  assign adv           = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
    out_valid_d = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  // sample masking
  logic [31:0]            samp_ext;
  logic [SAMPLE_BITS-1:0] samp;

  assign samp_ext = {16'b0, s_axis_tdata};
  assign samp     = samp_ext[SAMPLE_BITS-1:0];

  // window pointer and fill state
  logic [PtrW-1:0] wp_q, wp_d, wp_inc;
  logic            full_q, full_d;
  logic            mem_we;

  assign wp_inc = (wp_q == LastPtr) ? '0 : wp_q + 1'b1;
  assign mem_we = in_acc && (full_q || (samp != '0));

  always_comb begin
    wp_d   = mem_we ? wp_inc : wp_q;
    full_d = full_q || (mem_we && (wp_q == LastPtr));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      full_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      full_q      <= full_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // window ram: write the new sample, read the entry after it as the oldest
  logic [SAMPLE_BITS-1:0] win_mem [Window];
  logic [SAMPLE_BITS-1:0] s1_old_q;
  logic [SAMPLE_BITS-1:0] s1_samp_q;
  logic                   s1_cmp_q;
  logic                   s1_full_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[wp_q] <= samp;
    end
    if (in_acc) begin
      s1_old_q <= win_mem[wp_inc];
    end
  end

  // stage register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_samp_q <= samp;
      s1_cmp_q  <= full_q;
      s1_full_q <= full_d;
    end
  end

  // compare and hold update
  logic              hold_act_q, hold_act_d;
  logic [HoldW-1:0]  hold_cnt_q, hold_cnt_d;
  logic signed [DiffW-1:0] margin;
  logic              rise_hit, near_hit, det;

  assign margin = $signed(DiffW'(s1_samp_q)) - $signed(DiffW'(s1_old_q))
                - $signed(DiffW'(rise_thr_q));
  assign rise_hit = !margin[DiffW-1];
  assign near_hit = DiffW'(s1_samp_q) > DiffW'(near_lim_q);

  always_comb begin
    hold_act_d = hold_act_q;
    hold_cnt_d = hold_cnt_q;
    det        = 1'b0;
    if (s1_cmp_q) begin
      if (rise_hit) begin
        det        = 1'b1;
        hold_act_d = 1'b1;
      end
      if (hold_act_d && (hold_cnt_q < hold_len_q)) begin
        hold_cnt_d = hold_cnt_q + 1'b1;
        det        = 1'b1;
      end
      if (hold_cnt_d >= hold_len_q) begin
        hold_act_d = 1'b0;
        hold_cnt_d = '0;
      end
      if (near_hit) begin
        hold_cnt_d = '0;
        hold_act_d = 1'b1;
        det        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_act_q <= 1'b0;
      hold_cnt_q <= '0;
    end else if (adv) begin
      hold_act_q <= hold_act_d;
      hold_cnt_q <= hold_cnt_d;
    end
  end

  // result register
  logic out_det_q, out_full_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_det_q  <= det;
      out_full_q <= s1_full_q;
    end
  end

  always_comb begin
    m_axis_tdata                   = '0;
    m_axis_tdata[OutDetectedBit]   = out_det_q;
    m_axis_tdata[OutWindowFullBit] = out_full_q;
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

[rtl/prdh_checker.sv]
// port checker for the presence rise detector with hold, bound to the top level
module prdh_checker
  import prdh_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic [SampleFieldW-1:0] s_axis_tdata,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [OutDataW-1:0]     m_axis_tdata,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o,
  input logic [CfgIndexW-1:0]    cfg_index_i,
  input logic [CfgDataW-1:0]     cfg_data_i
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no detection is reported before the window is full
  a_no_det_filling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[OutWindowFullBit] |-> !m_axis_tdata[OutDetectedBit])
    else $error("detection while window filling");

  // unused result bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:2] == '0))
    else $error("result padding not zero");

  // input backpressure only when a result waits at the output
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

endmodule

bind presence_rise_detector_hold prdh_checker u_prdh_checker (.*);

[bench/testbench.sv]
// testbench for the presence rise detector with hold, with a self-checking scoreboard
`timescale 1ns / 1ps

module testbench;
  import prdh_pkg::*;

  localparam int unsigned WindowGroups = 8;
  localparam int unsigned SampleBits   = 16;
  localparam int unsigned WindowDepth  = 8 * WindowGroups;
  localparam int unsigned PtrW         = $clog2(WindowDepth);
  localparam int unsigned FillW        = $clog2(WindowDepth + 1);
  localparam logic [CfgIndexW-1:0] RegUnused = 2'd3;
  localparam int unsigned IdlePercent  = 29;
  localparam int unsigned RandomItems  = 1650;
  localparam int unsigned NumPhases    = 12;
  localparam int unsigned StallLimit   = 2000;

  // one result as predicted
  typedef struct packed {
    logic window_full;
    logic detected;
  } presence_result_t;

  // predicts detection per sample and checks results in order
  class presence_scoreboard;
    logic [SampleFieldW-1:0] window_mem [WindowDepth];
    logic [PtrW-1:0]         wr_ptr;
    logic [FillW-1:0]        fill_cnt;
    bit                      hold_on;
    logic [HoldW-1:0]        hold_cnt;
    logic [ThresholdW-1:0]   rise_thr;
    logic [HoldW-1:0]        hold_len;
    logic [ThresholdW-1:0]   near_lim;
    presence_result_t        expected_results [$];
    int                      errors;

    function new();
      rise_thr = RiseThresholdReset;
      hold_len = HoldLengthReset;
      near_lim = NearLimitReset;
      wr_ptr   = '0;
      fill_cnt = '0;
      hold_on  = 1'b0;
      hold_cnt = '0;
      errors   = 0;
    endfunction

    // register write seen by the block
    function void note_config(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegRiseThreshold: rise_thr = data;
        RegHoldLength:    hold_len = data[HoldW-1:0];
        RegNearLimit:     near_lim = data;
        default: ;
      endcase
    endfunction

    // accepted sample: update window and hold, queue the expected result
    function void note_sample(logic [SampleFieldW-1:0] raw);
      logic [SampleFieldW-1:0] s;
      logic [SampleFieldW-1:0] oldest;
      int                      diff;
      presence_result_t        r;
      s = '0;
      s[SampleBits-1:0] = raw[SampleBits-1:0];
      r.detected = 1'b0;
      if (fill_cnt < FillW'(WindowDepth)) begin
        // filling: zero readings are dropped
        if (s != '0) begin
          window_mem[wr_ptr] = s;
          wr_ptr   = wr_ptr + 1'b1;
          fill_cnt = fill_cnt + 1'b1;
        end
      end else begin
        window_mem[wr_ptr] = s;
        wr_ptr = wr_ptr + 1'b1;
        oldest = window_mem[wr_ptr];
        diff   = int'({1'b0, s}) - int'({1'b0, oldest});
        if (diff >= int'({1'b0, rise_thr})) begin
          r.detected = 1'b1;
          hold_on    = 1'b1;
        end
        if (hold_on && hold_cnt < hold_len) begin
          hold_cnt   = hold_cnt + 1'b1;
          r.detected = 1'b1;
        end
        if (hold_cnt >= hold_len) begin
          hold_on  = 1'b0;
          hold_cnt = '0;
        end
        // close target overrides and restarts the hold
        if (s > near_lim) begin
          hold_cnt   = '0;
          hold_on    = 1'b1;
          r.detected = 1'b1;
        end
      end
      r.window_full = (fill_cnt >= FillW'(WindowDepth));
      expected_results.push_back(r);
    endfunction

    // accepted result against the oldest expectation
    function void check_result(logic [OutDataW-1:0] data);
      presence_result_t        want;
      logic [OutDataW-1:0]     pad;
      if (expected_results.size() == 0) begin
        $display("%0t: result %h arrived with no sample pending", $time, data);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (data[OutDetectedBit] !== want.detected) begin
        $display("%0t: detected mismatch, expected %0b actual %0b",
                 $time, want.detected, data[OutDetectedBit]);
        errors++;
      end
      if (data[OutWindowFullBit] !== want.window_full) begin
        $display("%0t: window_full mismatch, expected %0b actual %0b",
                 $time, want.window_full, data[OutWindowFullBit]);
        errors++;
      end
      pad = data;
      pad[OutDetectedBit]   = 1'b0;
      pad[OutWindowFullBit] = 1'b0;
      if (pad !== '0) begin
        $display("%0t: unused result bits, expected %h actual %h", $time, {OutDataW{1'b0}}, pad);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [SampleFieldW-1:0] s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataW-1:0]     m_axis_tdata;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIndexW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]     cfg_data_i;

  presence_scoreboard results_board = new();
  bit                 calm;
  int                 walk_level;

  presence_rise_detector_hold #(
    .WINDOW_GROUPS(WindowGroups),
    .SAMPLE_BITS  (SampleBits)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random back-pressure and checking
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        results_board.check_result(m_axis_tdata);
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // watchdog on cycles without any request
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("presence_rise_detector_hold verification failed");
    $finish;
  end

  // one sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [SampleFieldW-1:0] s);
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    results_board.note_sample(s);
  endtask

  // one register write, valid left high for a following write
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    results_board.note_config(idx, data);
  endtask

  // all three registers back to back
  task automatic configure(input logic [CfgDataW-1:0] thr, input logic [CfgDataW-1:0] hold,
                           input logic [CfgDataW-1:0] near);
    write_reg(RegRiseThreshold, thr);
    write_reg(RegHoldLength, hold);
    write_reg(RegNearLimit, near);
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending and wait for every result
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (results_board.expected_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // distance readings: slow walk, steps, zeros and full-range noise
  function automatic logic [SampleFieldW-1:0] next_sample();
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 8) return '0;
    if (mode < 15) return SampleFieldW'($urandom());
    if (mode < 25) walk_level += int'($urandom_range(0, 6000));
    else if (mode < 30) walk_level -= int'($urandom_range(0, 6000));
    else walk_level += int'($urandom_range(0, 400)) - 200;
    if (walk_level < 1) walk_level = 1;
    if (walk_level > 65535) walk_level = 65535;
    return SampleFieldW'(walk_level);
  endfunction

  // stimulus
  initial begin
    logic [CfgDataW-1:0] thr;
    logic [CfgDataW-1:0] hold;
    logic [CfgDataW-1:0] near;
    calm          = 1'b0;
    walk_level    = 1500;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // out of range index must change nothing
    write_reg(RegUnused, 16'hFFFF);
    cfg_valid_i <= 1'b0;

    // fill with reset settings, zero readings dropped on the way
    send_sample('0);
    send_sample('0);
    for (int k = 0; k < WindowDepth; k++) begin
      if (k == WindowDepth / 2) send_sample('0);
      if (k == 0) send_sample(16'hFFFF);
      else if (k == 1) send_sample(16'd1);
      else send_sample(SampleFieldW'(1000 + 10 * k));
    end
    // window full: zero shifts in, near limit edges, rise from low entries
    send_sample('0);
    send_sample(16'd2600);
    send_sample(16'd2601);
    send_sample(16'hFFFF);
    send_sample(16'd1);
    send_sample(16'd3000);
    wait_drained();

    // zero hold: detection only on the sample itself
    configure(16'd0, 16'hFC00, 16'hFFFF);
    send_sample(16'd5);
    send_sample(16'hFFFF);
    send_sample(16'd0);
    send_sample(16'd5);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin thr = 16'd0;     hold = 16'd0;    near = 16'hFFFF; end
        1: begin thr = 16'hFFFF;  hold = 16'd1023; near = 16'd0;    end
        2: begin thr = 16'hFFFF;  hold = 16'hFFFF; near = 16'hFFFF; end
        3: begin thr = 16'd1;     hold = 16'd1;    near = 16'hFFFE; end
        default: begin
          thr  = ($urandom_range(0, 9) == 0) ? CfgDataW'($urandom())
                                             : CfgDataW'($urandom_range(0, 5000));
          hold = ($urandom_range(0, 9) == 0) ? CfgDataW'($urandom_range(0, 1023))
                                             : CfgDataW'($urandom_range(0, 30));
          hold[CfgDataW-1:HoldW] = (CfgDataW - HoldW)'($urandom());
          near = CfgDataW'($urandom_range(1500, 65535));
        end
      endcase
      configure(thr, hold, near);
      calm = (p == NumPhases / 2);
      for (int n = 0; n < RandomItems / NumPhases; n++) begin
        send_sample(next_sample());
      end
      wait_drained();
      calm = 1'b0;
    end

    if (results_board.errors == 0 && results_board.expected_results.size() == 0) begin
      $display("presence_rise_detector_hold verification clean");
    end else begin
      $display("presence_rise_detector_hold verification failed");
    end
    $finish;
  end

endmodule
